[sv/bptm_pkg.sv]
// ----------------------------------------------------------------------------
// Battery power threshold monitor package
// Shared types, register indexes and reset values for the monitor.
// ----------------------------------------------------------------------------
package bptm_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [7:0]  COUNT_MAX = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VBUS_DEBOUNCE_MS     = 3'd0,
		REG_CRITICAL_PACK_MV     = 3'd1,
		REG_CRITICAL_CONSECUTIVE = 3'd2,
		REG_CRITICAL_OVERRIDE    = 3'd3,
		REG_LOW_PERCENT          = 3'd4,
		REG_HYSTERESIS_PERCENT   = 3'd5
	} reg_idx_t;

	localparam logic [15:0] RST_VBUS_DEBOUNCE_MS     = 16'd200;
	localparam logic [15:0] RST_CRITICAL_PACK_MV     = 16'd0;
	localparam logic [7:0]  RST_CRITICAL_CONSECUTIVE = 8'd3;
	localparam logic        RST_CRITICAL_OVERRIDE    = 1'b0;
	localparam logic [6:0]  RST_LOW_PERCENT          = 7'd20;
	localparam logic [6:0]  RST_HYSTERESIS_PERCENT   = 7'd5;

	typedef struct packed {
		logic [15:0] vbus_debounce_ms;
		logic [15:0] critical_pack_mv;
		logic [7:0]  critical_consecutive;
		logic        critical_override;
		logic [6:0]  low_percent;
		logic [6:0]  hysteresis_percent;
	} cfg_t;

	typedef struct packed {
		logic        external_power;
		logic        telemetry_valid;
		logic        is_charging;
		logic [15:0] pack_mv;
		logic [6:0]  charge_percent;
		logic [31:0] time_ms;
	} sample_t;

	typedef struct packed {
		logic supply_connected;
		logic supply_disconnected;
		logic low_entered;
		logic low_left;
		logic critical_entered;
	} events_t;

endpackage

[sv/battery_power_threshold_monitor_core.sv]
// ----------------------------------------------------------------------------
// Battery power threshold monitor core
// Debounces external power and keeps low and critical battery latches.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the input channel (in_valid / in_stall); a transaction is
// taken at a rising edge with in_valid high and in_stall low. Every sample
// yields exactly one result on the output channel (out_valid / out_stall),
// carrying five event flags.
// A sample is held in the input register until the output register can take
// it, is evaluated by the state update logic and lands in the output
// register, which raises out_valid and keeps the result until it is taken.
// One sample is taken per cycle while in_stall is low; the state update for a
// sample completes in the cycle it leaves the input register, so the next
// sample sees it at once.
// When the receiver stalls, the result holds in the output register, the
// next sample waits in the input register, and in_stall rises.
// Reset (arst_n low) clears the debounce and latch state and loads the
// register defaults; the first sample afterwards seeds the power level.
// The configuration channel (cfg_valid / cfg_ready) is always ready; the user
// must write it only while no sample is in flight, as the block does not enforce this.
// ----------------------------------------------------------------------------
module battery_power_threshold_monitor_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bptm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           external_power,
	input  logic                           telemetry_valid,
	input  logic                           is_charging,
	input  logic [15:0]                    pack_mv,
	input  logic [6:0]                     charge_percent,
	input  logic [31:0]                    time_ms,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           supply_connected,
	output logic                           supply_disconnected,
	output logic                           low_entered,
	output logic                           low_left,
	output logic                           critical_entered
);
	import bptm_pkg::*;

	cfg_t    cfg;
	sample_t smp_s1;
	logic    valid_s1;
	logic    advance;
	events_t evt;
	events_t evt_q;
	logic    out_valid_q;

	bptm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			smp_s1 <= '{external_power:  external_power,
			            telemetry_valid: telemetry_valid,
			            is_charging:     is_charging,
			            pack_mv:         pack_mv,
			            charge_percent:  charge_percent,
			            time_ms:         time_ms};
		end
	end

	bptm_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (advance),
		.smp    (smp_s1),
		.evt    (evt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			evt_q <= evt;
		end
	end

	assign out_valid           = out_valid_q;
	assign supply_connected    = evt_q.supply_connected;
	assign supply_disconnected = evt_q.supply_disconnected;
	assign low_entered         = evt_q.low_entered;
	assign low_left            = evt_q.low_left;
	assign critical_entered    = evt_q.critical_entered;

endmodule

[sv/bptm_cfg.sv]
// ----------------------------------------------------------------------------
// Battery power threshold monitor configuration registers
// Holds the six threshold registers written through the configuration channel.
// ----------------------------------------------------------------------------
module bptm_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bptm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [15:0]                        cfg_data,
	output bptm_pkg::cfg_t                     cfg
);
	import bptm_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vbus_debounce_ms     <= RST_VBUS_DEBOUNCE_MS;
			cfg_q.critical_pack_mv     <= RST_CRITICAL_PACK_MV;
			cfg_q.critical_consecutive <= RST_CRITICAL_CONSECUTIVE;
			cfg_q.critical_override    <= RST_CRITICAL_OVERRIDE;
			cfg_q.low_percent          <= RST_LOW_PERCENT;
			cfg_q.hysteresis_percent   <= RST_HYSTERESIS_PERCENT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_VBUS_DEBOUNCE_MS:     cfg_q.vbus_debounce_ms     <= cfg_data;
				REG_CRITICAL_PACK_MV:     cfg_q.critical_pack_mv     <= cfg_data;
				REG_CRITICAL_CONSECUTIVE: cfg_q.critical_consecutive <= cfg_data[7:0];
				REG_CRITICAL_OVERRIDE:    cfg_q.critical_override    <= cfg_data[0];
				REG_LOW_PERCENT:          cfg_q.low_percent          <= cfg_data[6:0];
				REG_HYSTERESIS_PERCENT:   cfg_q.hysteresis_percent   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

endmodule

[sv/bptm_step.sv]
// ----------------------------------------------------------------------------
// Battery power threshold monitor sample evaluation
// Debounce and latch state, with the combinational update for one sample.
// ----------------------------------------------------------------------------
module bptm_step (
	input  logic               clk,
	input  logic               arst_n,
	input  bptm_pkg::cfg_t     cfg,
	input  logic               fire,
	input  bptm_pkg::sample_t  smp,
	output bptm_pkg::events_t  evt
);
	import bptm_pkg::*;

	logic        seeded_q, raw_level_q, stable_level_q;
	logic        low_latched_q, critical_latched_q;
	logic [31:0] raw_since_ms_q;
	logic [7:0]  low_sample_count_q;

	logic        seeded_n, raw_level_n, stable_level_n;
	logic        low_latched_n, critical_latched_n;
	logic [31:0] raw_since_ms_n;
	logic [7:0]  low_sample_count_n;

	logic [31:0] elapsed;
	logic [7:0]  release_pct;
	logic        hit;

	assign elapsed     = smp.time_ms - raw_since_ms_q;
	assign release_pct = {1'b0, cfg.low_percent} + {1'b0, cfg.hysteresis_percent};

	always_comb begin
		seeded_n           = seeded_q;
		raw_level_n        = raw_level_q;
		raw_since_ms_n     = raw_since_ms_q;
		stable_level_n     = stable_level_q;
		low_latched_n      = low_latched_q;
		critical_latched_n = critical_latched_q;
		low_sample_count_n = low_sample_count_q;
		evt                = '0;
		hit                = 1'b0;

		if (!seeded_q) begin
			seeded_n       = 1'b1;
			raw_level_n    = smp.external_power;
			raw_since_ms_n = smp.time_ms;
			stable_level_n = smp.external_power;
		end else if (smp.external_power != raw_level_q) begin
			raw_level_n    = smp.external_power;
			raw_since_ms_n = smp.time_ms;
		end else if (raw_level_q != stable_level_q &&
				elapsed >= {16'd0, cfg.vbus_debounce_ms}) begin
			stable_level_n           = raw_level_q;
			evt.supply_connected    = raw_level_q;
			evt.supply_disconnected = !raw_level_q;
		end

		if (smp.telemetry_valid) begin
			if (stable_level_n || smp.is_charging) begin
				if (low_latched_q) begin
					low_latched_n = 1'b0;
					evt.low_left  = 1'b1;
				end
				critical_latched_n = 1'b0;
				low_sample_count_n = '0;
			end else begin
				if (cfg.critical_pack_mv != '0) begin
					if (smp.pack_mv != '0 && smp.pack_mv <= cfg.critical_pack_mv) begin
						if (low_sample_count_q != COUNT_MAX)
							low_sample_count_n = low_sample_count_q + 8'd1;
					end else begin
						low_sample_count_n = '0;
					end
					hit = low_sample_count_n >= cfg.critical_consecutive;
				end
				if (cfg.critical_override) begin
					hit                = 1'b0;
					critical_latched_n = 1'b0;
				end
				if (!critical_latched_n && hit) begin
					critical_latched_n   = 1'b1;
					evt.critical_entered = 1'b1;
					if (!low_latched_n) begin
						low_latched_n   = 1'b1;
						evt.low_entered = 1'b1;
					end
				end
				// Entry wins over release; release is held off while critical.
				if (!low_latched_n && smp.charge_percent <= cfg.low_percent) begin
					low_latched_n   = 1'b1;
					evt.low_entered = 1'b1;
				end else if (low_latched_n && !critical_latched_n &&
						{1'b0, smp.charge_percent} >= release_pct) begin
					low_latched_n = 1'b0;
					evt.low_left  = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q           <= 1'b0;
			raw_level_q        <= 1'b0;
			raw_since_ms_q     <= '0;
			stable_level_q     <= 1'b0;
			low_latched_q      <= 1'b0;
			critical_latched_q <= 1'b0;
			low_sample_count_q <= '0;
		end else if (fire) begin
			seeded_q           <= seeded_n;
			raw_level_q        <= raw_level_n;
			raw_since_ms_q     <= raw_since_ms_n;
			stable_level_q     <= stable_level_n;
			low_latched_q      <= low_latched_n;
			critical_latched_q <= critical_latched_n;
			low_sample_count_q <= low_sample_count_n;
		end
	end

endmodule

[sv/bptm_checker.sv]
// ----------------------------------------------------------------------------
// Battery power threshold monitor checker
// Port-level properties of the monitor, bound to the top level.
// ----------------------------------------------------------------------------
module bptm_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic supply_connected,
	input logic supply_disconnected,
	input logic low_entered,
	input logic low_left,
	input logic critical_entered
);

	// A debounced level change goes one way only.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({supply_connected, supply_disconnected}))
		else $error("connect and disconnect in one result");

	// The low latch cannot be both set and released by one sample.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(low_entered && low_left))
		else $error("low latch entered and left in one result");

	// Entering critical keeps the low latch set.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && critical_entered) |-> !low_left)
		else $error("low latch released on critical entry");

	// A stalled result stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid &&
			$stable({supply_connected, supply_disconnected, low_entered,
				low_left, critical_entered})))
		else $error("stalled result changed");

endmodule

bind battery_power_threshold_monitor_core bptm_checker u_bptm_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.out_valid           (out_valid),
	.out_stall           (out_stall),
	.supply_connected    (supply_connected),
	.supply_disconnected (supply_disconnected),
	.low_entered         (low_entered),
	.low_left            (low_left),
	.critical_entered    (critical_entered)
);
